// ----- hdl/crfe_pkg.sv -----
// Shared types and constants for the cascaded rational function evaluator.
package crfe_pkg;

  localparam int unsigned MaxStages = 4;
  localparam int unsigned MaxCoeffs = 8;

  localparam int unsigned AccW  = 33;
  localparam int unsigned ProdW = 51;
  localparam int unsigned DivW  = 48;
  localparam int unsigned MagW  = 48;
  localparam int unsigned WideW = 96;

  localparam logic [MagW-1:0]  MagLimit = 48'h8000_0000_0000;
  localparam logic [MagW-1:0]  MagOne   = 48'h0000_0001_0000;
  localparam logic [WideW-1:0] MulMax   = 96'h7FFF_FFFF_FFFF_8000;

  typedef enum logic [1:0] {
    CMD_LOAD_NUM = 2'd0,
    CMD_LOAD_DEN = 2'd1,
    CMD_EVAL     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HSTART,
    ST_HRD,
    ST_HMUL,
    ST_HADD,
    ST_HEND,
    ST_DIV,
    ST_DIVEND,
    ST_MUL,
    ST_MULEND,
    ST_NEXT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [1:0]        stage_select;
    logic [2:0]        coef_index;
    logic signed [7:0] coef_value;
    logic              coef_last;
    logic [16:0]       x_value;
  } in_t;

  typedef struct packed {
    logic signed [47:0] product_value;
    logic               zero_denominator;
    logic               saturated;
  } out_t;

endpackage

// ----- hdl/cascaded_rational_function_eval_core.sv -----
// Cascaded rational function evaluator: top level with sequencer and shared datapath.
// A coefficient load is written into the table when it is accepted. An evaluate runs,
// for each used stage, a Horner pass over each polynomial with a table read, a
// multiply and a round and add per stored coefficient, then a restoring division
// and a product multiply (skipped on a zero denominator or quotient), with control
// states between. The Horner passes and the serial divider take nearly all of the
// evaluate time.
// The input is stalled while an evaluate runs; the result sits in an output
// register, so the next item is taken while it waits.
module cascaded_rational_function_eval_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  input  crfe_pkg::in_t  in_data_i,
  output logic           out_valid,
  input  logic           out_stall,
  output crfe_pkg::out_t out_data_o,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_data_i
);

  localparam int Depth = crfe_pkg::MaxStages * crfe_pkg::MaxCoeffs;
  localparam int AW    = $clog2(Depth);
  localparam int SIW   = (crfe_pkg::MaxStages > 1) ? $clog2(crfe_pkg::MaxStages) : 1;
  localparam int CW    = $clog2(crfe_pkg::MaxStages + 1);

  crfe_pkg::state_e state_q, state_d;

  logic [2:0]      stage_count_q;
  logic [7:0]      num_mem [Depth];
  logic [7:0]      den_mem [Depth];
  logic [Depth-1:0] num_vld_q, den_vld_q;
  logic [3:0]      num_len_q [crfe_pkg::MaxStages];
  logic [3:0]      den_len_q [crfe_pkg::MaxStages];
  logic [7:0]      rd_num_q, rd_den_q;

  logic [CW-1:0]   cnt_q, s_q;
  logic            phase_q;
  logic [3:0]      k_q;
  logic [16:0]     x_q;
  logic signed [crfe_pkg::AccW-1:0]  acc_q, num_q;
  logic signed [crfe_pkg::ProdW-1:0] prod_q;
  logic            sgn_q;
  logic [crfe_pkg::AccW-1:0]  rem_q;
  logic [crfe_pkg::AccW-2:0]  dm_q;
  logic [crfe_pkg::DivW-1:0]  dq_q;
  logic [5:0]      dcnt_q;
  logic [1:0]      mcnt_q;
  logic [crfe_pkg::WideW-1:0] p_q;
  logic [crfe_pkg::MagW-1:0]  mag_q;
  logic            neg_q, over_q, zden_q, zq_q;
  logic            out_valid_q;
  crfe_pkg::out_t  out_q;

  logic            in_acc, out_free, load_ok;
  logic [AW-1:0]   waddr, raddr;
  logic [CW-1:0]   s_next;
  logic [CW-1:0]   cnt_new;
  logic [crfe_pkg::ProdW-1:0] pm;
  logic [crfe_pkg::ProdW-1:0] rs;
  logic signed [crfe_pkg::AccW-1:0] racc, coef_ext, hsum;
  logic [crfe_pkg::AccW-1:0]  r2;
  logic [crfe_pkg::AccW-1:0]  nm, dmag;
  logic [crfe_pkg::MagW-1:0]  qm_ext;
  logic [15:0]     chunk;
  logic [63:0]     pp;
  logic [crfe_pkg::WideW-1:0] t_sum;
  logic            mul_over;
  crfe_pkg::out_t  res;

  assign in_stall  = (state_q != crfe_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_q || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_q;
  assign out_data_o = out_q;

  assign load_ok = (int'(in_data_i.stage_select) < crfe_pkg::MaxStages) &&
                   (int'(in_data_i.coef_index) < crfe_pkg::MaxCoeffs);
  assign waddr = AW'(int'(in_data_i.stage_select) * crfe_pkg::MaxCoeffs +
                     int'(in_data_i.coef_index));
  assign raddr = AW'(int'(s_q) * crfe_pkg::MaxCoeffs + int'(k_q) - 1);
  assign s_next = s_q + CW'(1);
  assign cnt_new = (int'(stage_count_q) > crfe_pkg::MaxStages) ? CW'(crfe_pkg::MaxStages)
                                                               : CW'(stage_count_q);

  always_comb begin
    pm = prod_q[crfe_pkg::ProdW-1] ? crfe_pkg::ProdW'(-prod_q) : crfe_pkg::ProdW'(prod_q);
    rs = (pm + crfe_pkg::ProdW'(32768)) >> 16;
    racc = prod_q[crfe_pkg::ProdW-1] ? -$signed(rs[crfe_pkg::AccW-1:0])
                                     : $signed(rs[crfe_pkg::AccW-1:0]);
    coef_ext = crfe_pkg::AccW'($signed(phase_q ? rd_den_q : rd_num_q)) <<< 16;
    hsum = racc + coef_ext;
    nm = num_q[crfe_pkg::AccW-1] ? crfe_pkg::AccW'(-num_q) : crfe_pkg::AccW'(num_q);
    dmag = acc_q[crfe_pkg::AccW-1] ? crfe_pkg::AccW'(-acc_q) : crfe_pkg::AccW'(acc_q);
    r2 = {rem_q[crfe_pkg::AccW-2:0], dq_q[crfe_pkg::DivW-1]};
    qm_ext = crfe_pkg::MagW'(dq_q);
    chunk = qm_ext[16*mcnt_q +: 16];
    pp = mag_q * chunk;
    t_sum = p_q + crfe_pkg::WideW'(32768);
    mul_over = (p_q > crfe_pkg::MulMax);
  end

  always_comb begin
    res = '0;
    if (zden_q || zq_q) begin
      res.zero_denominator = zden_q;
    end else if (neg_q) begin
      res.product_value = over_q ? -$signed(crfe_pkg::MagLimit) : -$signed(mag_q);
      res.saturated = over_q;
    end else if (over_q || mag_q > crfe_pkg::MagLimit - 48'd1) begin
      res.product_value = $signed(crfe_pkg::MagLimit - 48'd1);
      res.saturated = 1'b1;
    end else begin
      res.product_value = $signed(mag_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      crfe_pkg::ST_IDLE: begin
        if (in_acc && in_data_i.command == crfe_pkg::CMD_EVAL) begin
          state_d = (cnt_new == '0) ? crfe_pkg::ST_OUT : crfe_pkg::ST_HSTART;
        end
      end
      crfe_pkg::ST_HSTART: state_d = (k_q == '0) ? crfe_pkg::ST_HEND : crfe_pkg::ST_HRD;
      crfe_pkg::ST_HRD:    state_d = crfe_pkg::ST_HMUL;
      crfe_pkg::ST_HMUL:   state_d = crfe_pkg::ST_HADD;
      crfe_pkg::ST_HADD:   state_d = (k_q == 4'd1) ? crfe_pkg::ST_HEND : crfe_pkg::ST_HRD;
      crfe_pkg::ST_HEND: begin
        if (!phase_q) begin
          state_d = crfe_pkg::ST_HSTART;
        end else if (acc_q == '0) begin
          state_d = crfe_pkg::ST_NEXT;
        end else begin
          state_d = crfe_pkg::ST_DIV;
        end
      end
      crfe_pkg::ST_DIV:    state_d = (dcnt_q == 6'd1) ? crfe_pkg::ST_DIVEND : crfe_pkg::ST_DIV;
      crfe_pkg::ST_DIVEND: state_d = (dq_q == '0) ? crfe_pkg::ST_NEXT : crfe_pkg::ST_MUL;
      crfe_pkg::ST_MUL:    state_d = (mcnt_q == 2'd2) ? crfe_pkg::ST_MULEND : crfe_pkg::ST_MUL;
      crfe_pkg::ST_MULEND: state_d = crfe_pkg::ST_NEXT;
      crfe_pkg::ST_NEXT:   state_d = (s_next == cnt_q) ? crfe_pkg::ST_OUT : crfe_pkg::ST_HSTART;
      crfe_pkg::ST_OUT:    state_d = out_free ? crfe_pkg::ST_IDLE : crfe_pkg::ST_OUT;
      default:             state_d = crfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= 3'd1;
      num_vld_q     <= '0;
      den_vld_q     <= '0;
      num_len_q     <= '{default: '0};
      den_len_q     <= '{default: '0};
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        stage_count_q <= cfg_data_i;
      end
      if (in_acc && load_ok) begin
        if (in_data_i.command == crfe_pkg::CMD_LOAD_NUM) begin
          num_vld_q[waddr] <= 1'b1;
          if (in_data_i.coef_last) begin
            num_len_q[in_data_i.stage_select[SIW-1:0]] <= {1'b0, in_data_i.coef_index} + 4'd1;
          end
        end else if (in_data_i.command == crfe_pkg::CMD_LOAD_DEN) begin
          den_vld_q[waddr] <= 1'b1;
          if (in_data_i.coef_last) begin
            den_len_q[in_data_i.stage_select[SIW-1:0]] <= {1'b0, in_data_i.coef_index} + 4'd1;
          end
        end
      end
      if (state_q == crfe_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && load_ok && in_data_i.command == crfe_pkg::CMD_LOAD_NUM) begin
      num_mem[waddr] <= in_data_i.coef_value;
    end
    if (in_acc && load_ok && in_data_i.command == crfe_pkg::CMD_LOAD_DEN) begin
      den_mem[waddr] <= in_data_i.coef_value;
    end
    rd_num_q <= num_vld_q[raddr] ? num_mem[raddr] : 8'd0;
    rd_den_q <= den_vld_q[raddr] ? den_mem[raddr] : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      crfe_pkg::ST_IDLE: begin
        cnt_q   <= cnt_new;
        s_q     <= '0;
        phase_q <= 1'b0;
        k_q     <= num_len_q[0];
        acc_q   <= '0;
        x_q     <= in_data_i.x_value;
        mag_q   <= crfe_pkg::MagOne;
        neg_q   <= 1'b0;
        over_q  <= 1'b0;
        zden_q  <= 1'b0;
        zq_q    <= 1'b0;
      end
      crfe_pkg::ST_HMUL: begin
        prod_q <= crfe_pkg::ProdW'(acc_q) * crfe_pkg::ProdW'($signed({1'b0, x_q}));
      end
      crfe_pkg::ST_HADD: begin
        acc_q <= hsum;
        k_q   <= k_q - 4'd1;
      end
      crfe_pkg::ST_HEND: begin
        if (!phase_q) begin
          num_q   <= acc_q;
          acc_q   <= '0;
          phase_q <= 1'b1;
          k_q     <= den_len_q[s_q[SIW-1:0]];
        end else if (acc_q == '0) begin
          zden_q <= 1'b1;
        end else begin
          sgn_q  <= num_q[crfe_pkg::AccW-1] ^ acc_q[crfe_pkg::AccW-1];
          dm_q   <= dmag[crfe_pkg::AccW-2:0];
          dq_q   <= (crfe_pkg::DivW'(nm) << 16) + crfe_pkg::DivW'(dmag[crfe_pkg::AccW-1:1]);
          rem_q  <= '0;
          dcnt_q <= 6'(crfe_pkg::DivW);
        end
      end
      crfe_pkg::ST_DIV: begin
        if (r2 >= {1'b0, dm_q}) begin
          rem_q <= r2 - {1'b0, dm_q};
          dq_q  <= {dq_q[crfe_pkg::DivW-2:0], 1'b1};
        end else begin
          rem_q <= r2;
          dq_q  <= {dq_q[crfe_pkg::DivW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 6'd1;
      end
      crfe_pkg::ST_DIVEND: begin
        if (dq_q == '0) begin
          zq_q <= 1'b1;
        end else begin
          neg_q  <= neg_q ^ sgn_q;
          p_q    <= '0;
          mcnt_q <= '0;
        end
      end
      crfe_pkg::ST_MUL: begin
        p_q    <= p_q + (crfe_pkg::WideW'(pp) << (16 * mcnt_q));
        mcnt_q <= mcnt_q + 2'd1;
      end
      crfe_pkg::ST_MULEND: begin
        if (mul_over) begin
          over_q <= 1'b1;
          mag_q  <= crfe_pkg::MagLimit;
        end else begin
          mag_q <= t_sum[16 +: crfe_pkg::MagW];
          if (t_sum[16 +: crfe_pkg::MagW] == '0) begin
            zq_q <= 1'b1;
          end
        end
      end
      crfe_pkg::ST_NEXT: begin
        s_q     <= s_next;
        phase_q <= 1'b0;
        acc_q   <= '0;
        k_q     <= num_len_q[s_next[SIW-1:0]];
      end
      crfe_pkg::ST_OUT: begin
        if (out_free) begin
          out_q <= res;
        end
      end
      default: begin
      end
    endcase
  end

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.command == crfe_pkg::CMD_EVAL |=> state_q != crfe_pkg::ST_IDLE)
    else $error("evaluate transfer did not start the sequencer");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != crfe_pkg::ST_IDLE |-> mag_q <= crfe_pkg::MagLimit)
    else $error("product magnitude beyond limit");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crfe_pkg::ST_DIV |-> rem_q < {1'b0, dm_q})
    else $error("division remainder not below divisor");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.saturated |-> !out_data_o.zero_denominator)
    else $error("saturated and zero denominator both set");

endmodule
